@@ src/fspw_pkg.sv @@
// ----------------------------------------------------------------------------
// fspw_pkg
// Types and constants shared by the four-step phase wrap pipeline.
// ----------------------------------------------------------------------------
package fspw_pkg;

    localparam int IN_W          = 16;
    localparam int MASK_W        = 8;
    localparam int PHASE_W       = 16;
    localparam int CONF_W        = 17;
    localparam int CORDIC_STEPS  = 28;
    localparam int SQRT_STEPS    = 17;
    localparam int ANGLE_BITS    = 30;
    localparam int PRESHIFT      = 28;
    localparam int DIFF_W        = 17;
    localparam int SQR_W         = 32;
    localparam int XY_W          = 48;
    localparam int Z_W           = 35;
    localparam int SQ_W          = 34;

    localparam logic [MASK_W-1:0] MASK_FULL = 8'hFF;

    localparam logic signed [Z_W-1:0] PI_Q30     = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] TWO_PI_Q30 = 35'sd6746518852;

    // configuration register indexes
    localparam logic REG_SAT_LEVEL = 1'b0;
    localparam logic REG_MAX_SAT   = 1'b1;

    localparam logic [Z_W-1:0] ATAN_LOW [10] = '{
        35'd843314857, 35'd497837829, 35'd263043837, 35'd133525159, 35'd67021687,
        35'd33543516,  35'd16775851,  35'd8388437,   35'd4194283,   35'd2097149
    };

    typedef struct packed {
        logic              valid;
        logic              good;
        logic              processed;
        logic [MASK_W-1:0] mask;
    } fspw_ctl_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   skip;
        logic [SQ_W-1:0]        rem;
        logic [SQ_W-1:0]        root;
    } fspw_data_t;

    // atan(2^-i) in Q30; below 2^-10 the angle equals the tangent
    function automatic logic [Z_W-1:0] atan_q30(input int i);
        logic [Z_W-1:0] val;
        if (i < 10)
            val = ATAN_LOW[4'(i)];
        else
            val = Z_W'(1) << (ANGLE_BITS - i);
        return val;
    endfunction

endpackage

@@ src/fspw_front.sv @@
// ----------------------------------------------------------------------------
// fspw_front
// Input stages: saturation check, differences, squares, pre-rotation.
// ----------------------------------------------------------------------------
module fspw_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic [fspw_pkg::IN_W-1:0]         s1,
    input  logic [fspw_pkg::IN_W-1:0]         s2,
    input  logic [fspw_pkg::IN_W-1:0]         s3,
    input  logic [fspw_pkg::IN_W-1:0]         s4,
    input  logic [fspw_pkg::MASK_W-1:0]       mask,
    input  logic [fspw_pkg::IN_W-1:0]         sat_level,
    input  logic [2:0]                        max_sat,
    output fspw_pkg::fspw_ctl_t               ctl_out,
    output fspw_pkg::fspw_data_t              data_out
);

    localparam logic [fspw_pkg::IN_W-1:0] SMASK =
        fspw_pkg::IN_W'((32'd1 << SAMPLE_WIDTH) - 32'd1);
    localparam int XY_PAD = fspw_pkg::XY_W - (fspw_pkg::DIFF_W + 1) - fspw_pkg::PRESHIFT;

    logic [fspw_pkg::IN_W-1:0] m1, m2, m3, m4;
    logic [2:0]                sat_cnt;
    logic                      full_mask, reject;
    fspw_pkg::fspw_ctl_t       ctl1_next, ctl1_reg, ctl2_reg, ctl3_reg;

    logic signed [fspw_pkg::DIFF_W-1:0] a_next, b_next, a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [2*fspw_pkg::DIFF_W-1:0] aa_full, bb_full;
    logic [fspw_pkg::SQR_W-1:0]         aa_reg, bb_reg;

    logic signed [fspw_pkg::DIFF_W:0]   xs, ys;
    fspw_pkg::fspw_data_t               d3_next, d3_reg;

    assign m1 = s1 & SMASK;
    assign m2 = s2 & SMASK;
    assign m3 = s3 & SMASK;
    assign m4 = s4 & SMASK;

    assign sat_cnt = 3'(m1 == sat_level) + 3'(m2 == sat_level)
                   + 3'(m3 == sat_level) + 3'(m4 == sat_level);
    assign full_mask = (mask == fspw_pkg::MASK_FULL);
    assign reject    = sat_cnt > max_sat;

    always_comb
    begin
        ctl1_next.valid     = load;
        ctl1_next.processed = full_mask;
        ctl1_next.good      = full_mask && !reject;
        ctl1_next.mask      = (full_mask && reject) ? '0 : mask;
    end

    assign a_next = $signed({1'b0, m4}) - $signed({1'b0, m2});
    assign b_next = $signed({1'b0, m1}) - $signed({1'b0, m3});

    assign aa_full = a1_reg * a1_reg;
    assign bb_full = b1_reg * b1_reg;

    // turn the left half-plane by pi; the start angle already holds the +pi offset
    always_comb
    begin
        if (b2_reg < 0)
        begin
            xs = -{b2_reg[fspw_pkg::DIFF_W-1], b2_reg};
            ys = -{a2_reg[fspw_pkg::DIFF_W-1], a2_reg};
            d3_next.z = (a2_reg >= 0) ? fspw_pkg::TWO_PI_Q30 : '0;
        end
        else
        begin
            xs = {b2_reg[fspw_pkg::DIFF_W-1], b2_reg};
            ys = {a2_reg[fspw_pkg::DIFF_W-1], a2_reg};
            d3_next.z = fspw_pkg::PI_Q30;
        end
        d3_next.x    = {{XY_PAD{xs[fspw_pkg::DIFF_W]}}, xs, {fspw_pkg::PRESHIFT{1'b0}}};
        d3_next.y    = {{XY_PAD{ys[fspw_pkg::DIFF_W]}}, ys, {fspw_pkg::PRESHIFT{1'b0}}};
        d3_next.skip = (a2_reg == 0);
        d3_next.rem  = {2'b00, aa_reg} + {2'b00, bb_reg};
        d3_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg <= a_next;
        b1_reg <= b_next;
        a2_reg <= a1_reg;
        b2_reg <= b1_reg;
        aa_reg <= aa_full[fspw_pkg::SQR_W-1:0];
        bb_reg <= bb_full[fspw_pkg::SQR_W-1:0];
        d3_reg <= d3_next;
    end

    assign ctl_out  = ctl3_reg;
    assign data_out = d3_reg;

endmodule

@@ src/fspw_cell.sv @@
// ----------------------------------------------------------------------------
// fspw_cell
// One pipeline cell: a CORDIC vectoring step and, in the first cells,
// one digit of the integer square root.
// ----------------------------------------------------------------------------
module fspw_cell #(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fspw_pkg::fspw_ctl_t  ctl_in,
    input  fspw_pkg::fspw_data_t data_in,
    output fspw_pkg::fspw_ctl_t  ctl_out,
    output fspw_pkg::fspw_data_t data_out
);

    localparam logic signed [fspw_pkg::Z_W-1:0] ATAN_STEP =
        $signed(fspw_pkg::atan_q30(STAGE));

    logic signed [fspw_pkg::XY_W-1:0] x_in, y_in, dx, dy;
    logic signed [fspw_pkg::Z_W-1:0]  z_in;
    logic [fspw_pkg::SQ_W-1:0]        rem_next, root_next;
    fspw_pkg::fspw_data_t             data_next, data_reg;
    fspw_pkg::fspw_ctl_t              ctl_reg;

    assign x_in = data_in.x;
    assign y_in = data_in.y;
    assign z_in = data_in.z;
    assign dx   = y_in >>> STAGE;
    assign dy   = x_in >>> STAGE;

    generate
        if (STAGE < fspw_pkg::SQRT_STEPS)
        begin : g_sqrt
            localparam logic [fspw_pkg::SQ_W-1:0] SQ_BIT =
                fspw_pkg::SQ_W'(1) << (2 * (fspw_pkg::SQRT_STEPS - 1 - STAGE));
            logic [fspw_pkg::SQ_W-1:0] trial;

            assign trial = data_in.root + SQ_BIT;

            always_comb
            begin
                if (data_in.rem >= trial)
                begin
                    rem_next  = data_in.rem - trial;
                    root_next = (data_in.root >> 1) + SQ_BIT;
                end
                else
                begin
                    rem_next  = data_in.rem;
                    root_next = data_in.root >> 1;
                end
            end
        end
        else
        begin : g_pass
            assign rem_next  = data_in.rem;
            assign root_next = data_in.root;
        end
    endgenerate

    always_comb
    begin
        data_next      = data_in;
        data_next.rem  = rem_next;
        data_next.root = root_next;
        if (!data_in.skip)
        begin
            if (!y_in[fspw_pkg::XY_W-1])
            begin
                data_next.x = x_in + dx;
                data_next.y = y_in - dy;
                data_next.z = z_in + ATAN_STEP;
            end
            else
            begin
                data_next.x = x_in - dx;
                data_next.y = y_in + dy;
                data_next.z = z_in - ATAN_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign ctl_out  = ctl_reg;
    assign data_out = data_reg;

endmodule

@@ src/four_step_phase_wrap_core.sv @@
// ----------------------------------------------------------------------------
// four_step_phase_wrap_core
// Wrapped phase and modulation of four-step fringe data, one pixel a clock.
// ----------------------------------------------------------------------------
// channel   | handshake          | payload
// config    | cfg_wr             | cfg_index, cfg_data
// pixel in  | start & !busy      | sample_one..sample_four, mask_in
// result    | done (one cycle)   | phase, confidence, mask_out, processed
//
// One word per clock; busy never rises. Each word passes through three front
// stages, 28 CORDIC cells (the first 17 also run one square-root digit each)
// and the output register.
// Reset clears the valid chain and loads the register defaults (255, 1).
// The receiver cannot stall; done is a one-cycle strobe per word.
// ----------------------------------------------------------------------------
module four_step_phase_wrap_core #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int PHASE_FRAC_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic                                cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [fspw_pkg::IN_W-1:0]           sample_one,
    input  logic [fspw_pkg::IN_W-1:0]           sample_two,
    input  logic [fspw_pkg::IN_W-1:0]           sample_three,
    input  logic [fspw_pkg::IN_W-1:0]           sample_four,
    input  logic [fspw_pkg::MASK_W-1:0]         mask_in,
    output logic                                done,
    output logic signed [fspw_pkg::PHASE_W-1:0] phase,
    output logic [fspw_pkg::CONF_W-1:0]         confidence,
    output logic [fspw_pkg::MASK_W-1:0]         mask_out,
    output logic                                processed
);

    localparam int LATENCY     = 4 + fspw_pkg::CORDIC_STEPS;
    localparam int ROUND_SHIFT = fspw_pkg::ANGLE_BITS - PHASE_FRAC_BITS;
    localparam logic [31:0] INVALID_32 = 32'd0 - (32'd1 << PHASE_FRAC_BITS);
    localparam logic [fspw_pkg::PHASE_W-1:0] PHASE_INVALID =
        INVALID_32[fspw_pkg::PHASE_W-1:0];
    localparam logic [fspw_pkg::Z_W-1:0] ROUND_HALF =
        fspw_pkg::Z_W'(1) << (ROUND_SHIFT - 1);

    logic [15:0] sat_level_reg;
    logic [2:0]  max_sat_reg;

    fspw_pkg::fspw_ctl_t  chain_ctl  [fspw_pkg::CORDIC_STEPS+1];
    fspw_pkg::fspw_data_t chain_data [fspw_pkg::CORDIC_STEPS+1];

    fspw_pkg::fspw_ctl_t  last_ctl;
    fspw_pkg::fspw_data_t last_data;
    logic [fspw_pkg::Z_W-1:0]    z_clamp, z_round;
    logic [fspw_pkg::PHASE_W-1:0] phase_next, phase_reg;
    logic [fspw_pkg::CONF_W-1:0]  conf_next, conf_reg;
    logic [fspw_pkg::MASK_W-1:0]  mask_reg;
    logic                         done_reg, proc_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_level_reg <= 16'd255;
            max_sat_reg   <= 3'd1;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                fspw_pkg::REG_SAT_LEVEL: sat_level_reg <= cfg_data;
                fspw_pkg::REG_MAX_SAT:   max_sat_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    fspw_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (start && !busy),
        .s1        (sample_one),
        .s2        (sample_two),
        .s3        (sample_three),
        .s4        (sample_four),
        .mask      (mask_in),
        .sat_level (sat_level_reg),
        .max_sat   (max_sat_reg),
        .ctl_out   (chain_ctl[0]),
        .data_out  (chain_data[0])
    );

    generate
        for (genvar g = 0; g < fspw_pkg::CORDIC_STEPS; g++)
        begin : g_cell
            fspw_cell #(
                .STAGE (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl_in   (chain_ctl[g]),
                .data_in  (chain_data[g]),
                .ctl_out  (chain_ctl[g+1]),
                .data_out (chain_data[g+1])
            );
        end
    endgenerate

    assign last_ctl  = chain_ctl[fspw_pkg::CORDIC_STEPS];
    assign last_data = chain_data[fspw_pkg::CORDIC_STEPS];

    // angle already carries the +pi offset; clamp below zero, round half up
    assign z_clamp = last_data.z[fspw_pkg::Z_W-1] ? '0 : last_data.z;
    assign z_round = z_clamp + ROUND_HALF;

    always_comb
    begin
        if (last_ctl.good)
        begin
            phase_next = fspw_pkg::PHASE_W'(z_round >> ROUND_SHIFT);
            conf_next  = fspw_pkg::CONF_W'(last_data.root)
                       + fspw_pkg::CONF_W'(last_data.rem > last_data.root);
        end
        else
        begin
            phase_next = PHASE_INVALID;
            conf_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        conf_reg  <= conf_next;
        mask_reg  <= last_ctl.mask;
        proc_reg  <= last_ctl.processed;
    end

    assign done       = done_reg;
    assign phase      = $signed(phase_reg);
    assign confidence = conf_reg;
    assign mask_out   = mask_reg;
    assign processed  = proc_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result word missing at fixed latency");

    a_unprocessed_word: assert property (@(posedge clk) disable iff (!rst_n)
        done && !processed |-> phase_reg == PHASE_INVALID && confidence == '0)
        else $error("unprocessed word carries phase or confidence");

    a_processed_mask: assert property (@(posedge clk) disable iff (!rst_n)
        done && processed |-> mask_out == fspw_pkg::MASK_FULL || mask_out == '0)
        else $error("processed word has a partial mask");

    a_rejected_word: assert property (@(posedge clk) disable iff (!rst_n)
        done && processed && mask_out == '0 |-> confidence == '0)
        else $error("saturated word carries confidence");

endmodule

@@ tb/four_step_phase_wrap_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_step_phase_wrap_core_tb
// Self-checking bench for the four-step phase wrap pipeline. Pixels are driven
// through the start/busy port and every done word is checked against an
// in-bench CORDIC/sqrt predictor, through directed corners and random traffic
// under several saturation settings and sender idle patterns.
// ----------------------------------------------------------------------------
module four_step_phase_wrap_core_tb;

    localparam int FRAC_BITS = 12;
    localparam int ROUND_SHIFT = 30 - FRAC_BITS;
    localparam logic [15:0] PHASE_INVALID = 16'(-(1 << FRAC_BITS));
    localparam longint HALF_TURN_Q30 = 64'sd3373259426;
    localparam int ROTATIONS = 28;
    localparam int PIPE_DEPTH = 32;
    localparam longint ARCTAN_Q30 [10] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149
    };

    typedef struct packed {
        logic [15:0] ph;
        logic [16:0] conf;
        logic [7:0]  msk;
        logic        proc;
    } pixel_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        start;
    logic        busy;
    logic [15:0] sample_one;
    logic [15:0] sample_two;
    logic [15:0] sample_three;
    logic [15:0] sample_four;
    logic [7:0]  mask_in;
    logic        done;
    logic signed [15:0] phase;
    logic [16:0] confidence;
    logic [7:0]  mask_out;
    logic        processed;

    // shadow of the block's registers
    logic [15:0] sat_level = 16'd255;
    logic [2:0]  max_sat   = 3'd1;

    pixel_result_t pending_pixels [$];
    int errors = 0;
    int words_checked = 0;
    int words_processed = 0;
    int words_saturated = 0;
    int words_sent = 0;
    int settings_used = 1;

    four_step_phase_wrap_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .sample_one   (sample_one),
        .sample_two   (sample_two),
        .sample_three (sample_three),
        .sample_four  (sample_four),
        .mask_in      (mask_in),
        .done         (done),
        .phase        (phase),
        .confidence   (confidence),
        .mask_out     (mask_out),
        .processed    (processed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Timeout: %0d words still outstanding", pending_pixels.size());
        $display("Simulation FAILED");
        $finish;
    end

    // pi + atan2(a, b) by vectoring CORDIC, Q30 angle rounded to FRAC_BITS
    function automatic logic [15:0] wrapped_angle(input longint a, input longint b);
        longint x, y, z, dx, dy, step_angle, total;
        x = b;
        y = a;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
            x = -x;
            y = -y;
        end
        if (y != 0)
        begin
            x = x <<< 28;
            y = y <<< 28;
            for (int i = 0; i < ROTATIONS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                step_angle = (i < 10) ? ARCTAN_Q30[i] : (longint'(1) <<< (30 - i));
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + step_angle;
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - step_angle;
                end
            end
        end
        total = HALF_TURN_Q30 + z;
        if (total < 0)
            total = 0;
        return 16'((total + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);
    endfunction

    // nearest integer to sqrt(n)
    function automatic logic [16:0] rounded_magnitude(input longint n);
        longint r, cand;
        r = 0;
        for (int bitpos = 17; bitpos >= 0; bitpos--)
        begin
            cand = r | (longint'(1) <<< bitpos);
            if (cand * cand <= n)
                r = cand;
        end
        if (n > r * r + r)
            r = r + 1;
        return 17'(r);
    endfunction

    function automatic pixel_result_t predict_pixel(input logic [15:0] s1, input logic [15:0] s2,
                                                    input logic [15:0] s3, input logic [15:0] s4,
                                                    input logic [7:0] m);
        pixel_result_t r;
        int hits;
        longint a, b;
        hits = int'(s1 == sat_level) + int'(s2 == sat_level)
             + int'(s3 == sat_level) + int'(s4 == sat_level);
        r.ph   = PHASE_INVALID;
        r.conf = '0;
        r.msk  = m;
        r.proc = 1'b0;
        if (m == fspw_pkg::MASK_FULL)
        begin
            r.proc = 1'b1;
            if (hits > int'(max_sat))
                r.msk = 8'd0;
            else
            begin
                a = longint'(s4) - longint'(s2);
                b = longint'(s1) - longint'(s3);
                r.ph   = wrapped_angle(a, b);
                r.conf = rounded_magnitude(a * a + b * b);
            end
        end
        return r;
    endfunction

    // drive one pixel, hold until taken, then log its expected word
    task automatic push_pixel(input logic [15:0] s1, input logic [15:0] s2,
                              input logic [15:0] s3, input logic [15:0] s4,
                              input logic [7:0] m);
        @(negedge clk);
        start        = 1'b1;
        sample_one   = s1;
        sample_two   = s2;
        sample_three = s3;
        sample_four  = s4;
        mask_in      = m;
        do
            @(posedge clk);
        while (busy);
        pending_pixels = {pending_pixels, predict_pixel(s1, s2, s3, s4, m)};
        words_sent++;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        start = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_wr    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr = 1'b0;
        if (idx == fspw_pkg::REG_SAT_LEVEL)
            sat_level = val;
        else
            max_sat = val[2:0];
    endtask

    task automatic apply_setting(input logic [15:0] level, input logic [15:0] limit);
        drain_pipeline();
        write_reg(fspw_pkg::REG_SAT_LEVEL, level);
        write_reg(fspw_pkg::REG_MAX_SAT, limit);
        settings_used++;
    endtask

    // skews toward the saturation level, the range ends and the middle of the range
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1: return sat_level;
            2: return 16'd0;
            3: return 16'hFFFF;
            4, 5: return 16'(32768 - 100 + $urandom_range(0, 200));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_mask_gating();
        push_pixel(16'd1000, 16'd20, 16'd300, 16'd4000, 8'd0);
        push_pixel(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'd254);
        push_pixel(16'd255, 16'd255, 16'd255, 16'd255, 8'd127);
    endtask

    task automatic test_special_angles();
        push_pixel(16'd0, 16'd0, 16'd0, 16'd0, 8'hFF);           // a = b = 0
        push_pixel(16'd100, 16'd5, 16'd0, 16'd5, 8'hFF);         // a = 0, b > 0
        push_pixel(16'd0, 16'd9, 16'hFFFF, 16'd9, 8'hFF);        // a = 0, b < 0
        push_pixel(16'd7, 16'd0, 16'd7, 16'hFFFF, 8'hFF);        // b = 0, a > 0
        push_pixel(16'd7, 16'hFFFF, 16'd7, 16'd0, 8'hFF);        // b = 0, a < 0
        push_pixel(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'hFF);
        push_pixel(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 8'hFF);
        push_pixel(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 8'hFF);
        push_pixel(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_pixel(16'd12, 16'd3000, 16'd40000, 16'd2999, 8'hFF);
    endtask

    task automatic test_saturation_limits();
        push_pixel(16'd255, 16'd10, 16'd20, 16'd30, 8'hFF);      // one hit, allowed
        push_pixel(16'd255, 16'd10, 16'd255, 16'd30, 8'hFF);     // two hits, rejected
        push_pixel(16'd255, 16'd255, 16'd255, 16'd255, 8'hFF);
        apply_setting(16'd255, 16'd0);
        push_pixel(16'd1, 16'd255, 16'd2, 16'd3, 8'hFF);
        apply_setting(16'd0, 16'd4);
        push_pixel(16'd0, 16'd0, 16'd0, 16'd0, 8'hFF);           // four hits, limit four
        apply_setting(16'd0, 16'd3);
        push_pixel(16'd0, 16'd0, 16'd0, 16'd0, 8'hFF);
    endtask

    task automatic run_random(input logic [15:0] level, input logic [15:0] limit,
                              input int count, input int idle_pct);
        logic [15:0] s1, s2, s3, s4;
        logic [7:0] m;
        apply_setting(level, limit);
        for (int n = 0; n < count; n++)
        begin
            s1 = pick_sample();
            s2 = pick_sample();
            s3 = pick_sample();
            s4 = pick_sample();
            if ($urandom_range(0, 9) == 0)
                s4 = s2;
            if ($urandom_range(0, 9) == 0)
                s3 = s1;
            m = ($urandom_range(0, 99) < 85) ? fspw_pkg::MASK_FULL : 8'($urandom);
            push_pixel(s1, s2, s3, s4, m);
            // each cycle idles with the given odds
            while ($urandom_range(0, 99) < idle_pct)
            begin
                @(negedge clk);
                start = 1'b0;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random(16'd255, 16'd1, 120, 0);
        run_random(16'd0, 16'd0, 120, 83);
        run_random(16'hFFFF, 16'd4, 120, 18);
        run_random(16'($urandom), 16'd2, 120, 0);
        run_random(16'($urandom), 16'hFFFF, 120, 83);    // upper data bits dropped: limit 7
        run_random(16'd1, 16'd5, 120, 18);
        run_random(16'($urandom_range(0, 511)), 16'd3, 120, 0);
        run_random(16'($urandom), 16'd6, 110, 83);
    endtask

    task automatic note_mismatch(input string what, input pixel_result_t want);
        errors++;
        if (errors <= 10)
            $display("%0t %s: exp ph=%0d conf=%0d mask=%0d proc=%0b got ph=%0d conf=%0d mask=%0d proc=%0b",
                     $realtime, what, $signed(want.ph), want.conf, want.msk, want.proc,
                     phase, confidence, mask_out, processed);
    endtask

    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
                note_mismatch("unexpected word", '0);
            else
            begin
                want = pending_pixels.pop_front();
                words_checked++;
                if (want.proc && want.msk == 8'd0)
                    words_saturated++;
                else if (want.proc)
                    words_processed++;
                if (phase !== want.ph || confidence !== want.conf
                    || mask_out !== want.msk || processed !== want.proc)
                    note_mismatch("word mismatch", want);
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr       = 1'b0;
        cfg_index    = fspw_pkg::REG_SAT_LEVEL;
        cfg_data     = '0;
        start        = 1'b0;
        sample_one   = '0;
        sample_two   = '0;
        sample_three = '0;
        sample_four  = '0;
        mask_in      = '0;
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;

        test_mask_gating();
        test_special_angles();
        test_saturation_limits();
        test_random_traffic();

        drain_pipeline();
        repeat (PIPE_DEPTH + 8)
            @(posedge clk);
        errors += pending_pixels.size();

        $display("Sent %0d pixels over %0d register settings; %0d words checked",
                 words_sent, settings_used, words_checked);
        $display("%0d processed, %0d saturated, %0d masked off, %0d mismatches",
                 words_processed, words_saturated,
                 words_checked - words_processed - words_saturated, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
